[rtl/core/rabs_pkg.sv]
// shared types and constants for the rotated table search block
package rabs_pkg;

    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int DATA_W          = 32;
    localparam int IDX_W           = 10;
    localparam int LH_W            = IDX_W + 2;
    localparam int CFG_IDX_W       = 1;
    localparam int CFG_DATA_W      = IDX_W;

    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LOW  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_HIGH = 1'b1;

    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_SEARCH = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_LO,
        S_RD_MID,
        S_RD_HI,
        S_EVAL,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        RD_LO,
        RD_MID,
        RD_HI
    } rd_sel_t;

    typedef struct packed {
        logic    mem_wr;
        logic    load;
        rd_sel_t rd_sel;
        logic    cap_vl;
        logic    cap_vm;
        logic    step;
        logic    res_clear;
        logic    out_load;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic hit;
        logic dead;
        logic out_free;
    } sts_t;

endpackage

[rtl/core/rabs_intf.sv]
// request and result channel interfaces
interface rabs_req_if;
    logic                                valid;
    logic                                ready;
    logic                                req_type;
    logic        [rabs_pkg::IDX_W-1:0]   entry_index;
    logic signed [rabs_pkg::DATA_W-1:0]  item_value;

    modport source (output valid, output req_type, output entry_index, output item_value,
                    input ready);
    modport sink (input valid, input req_type, input entry_index, input item_value,
                  output ready);
endinterface

interface rabs_res_if;
    logic                        valid;
    logic                        ready;
    logic                        found;
    logic [rabs_pkg::IDX_W-1:0]  match_index;

    modport source (output valid, output found, output match_index, input ready);
    modport sink (input valid, input found, input match_index, output ready);
endinterface

[rtl/core/rabs_ctrl.sv]
// search sequencer state machine
module rabs_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    input  logic             req_type,
    output logic             req_ready,
    input  rabs_pkg::sts_t   sts,
    output rabs_pkg::cmd_t   cmd
);

    rabs_pkg::state_t state_reg;
    rabs_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rabs_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        req_ready     = 1'b0;
        cmd           = '0;
        cmd.rd_sel    = rabs_pkg::RD_LO;
        unique case (state_reg)
            rabs_pkg::S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    if (req_type == rabs_pkg::REQ_SEARCH)
                    begin
                        cmd.load   = 1'b1;
                        state_next = rabs_pkg::S_RD_LO;
                    end
                    else
                    begin
                        cmd.mem_wr = 1'b1;
                    end
                end
            end
            rabs_pkg::S_RD_LO:
            begin
                if (sts.empty)
                begin
                    cmd.res_clear = 1'b1;
                    state_next    = rabs_pkg::S_DONE;
                end
                else
                begin
                    cmd.rd_sel = rabs_pkg::RD_LO;
                    state_next = rabs_pkg::S_RD_MID;
                end
            end
            rabs_pkg::S_RD_MID:
            begin
                cmd.rd_sel = rabs_pkg::RD_MID;
                cmd.cap_vl = 1'b1;
                state_next = rabs_pkg::S_RD_HI;
            end
            rabs_pkg::S_RD_HI:
            begin
                cmd.rd_sel = rabs_pkg::RD_HI;
                cmd.cap_vm = 1'b1;
                state_next = rabs_pkg::S_EVAL;
            end
            rabs_pkg::S_EVAL:
            begin
                cmd.step = 1'b1;
                if (sts.hit || sts.dead)
                begin
                    state_next = rabs_pkg::S_DONE;
                end
                else
                begin
                    state_next = rabs_pkg::S_RD_LO;
                end
            end
            rabs_pkg::S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = rabs_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = rabs_pkg::S_IDLE;
            end
        endcase
    end

endmodule

[rtl/core/rabs_dp.sv]
// table memory, search bounds, probe compare and result register
module rabs_dp
#(
    parameter int TABLE_DEPTH = rabs_pkg::TABLE_DEPTH_DEF
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic        [rabs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic        [rabs_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic        [rabs_pkg::IDX_W-1:0]     entry_index,
    input  logic signed [rabs_pkg::DATA_W-1:0]    item_value,
    input  logic                                  res_ready,
    output logic                                  res_valid,
    output logic                                  res_found,
    output logic        [rabs_pkg::IDX_W-1:0]     res_match_index,
    input  rabs_pkg::cmd_t                        cmd,
    output rabs_pkg::sts_t                        sts
);

    localparam int AW     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int HI_MAX = TABLE_DEPTH - 1;
    localparam int LW     = rabs_pkg::LH_W;
    localparam int IW     = rabs_pkg::IDX_W;

    logic signed [rabs_pkg::DATA_W-1:0] mem [TABLE_DEPTH];
    logic signed [rabs_pkg::DATA_W-1:0] rd_data_reg;
    logic signed [rabs_pkg::DATA_W-1:0] vl_reg;
    logic signed [rabs_pkg::DATA_W-1:0] vm_reg;
    logic signed [rabs_pkg::DATA_W-1:0] target_reg;
    logic        [IW-1:0]               range_low_reg;
    logic        [IW-1:0]               range_high_reg;
    logic signed [LW-1:0]               lo_reg;
    logic signed [LW-1:0]               hi_reg;
    logic signed [LW-1:0]               hi_init;
    logic        [LW:0]                 sum_w;
    logic        [LW-1:0]               mid_w;
    logic        [IW-1:0]               rd_idx;
    logic        [AW-1:0]               rd_addr;
    logic                               wr_en;
    logic                               left_sorted;
    logic                               right_sorted;
    logic                               in_left;
    logic                               in_right;
    logic                               out_valid_reg;
    logic                               found_reg;
    logic        [IW-1:0]               match_reg;
    logic                               res_found_reg;
    logic        [IW-1:0]               res_idx_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_low_reg  <= '0;
            range_high_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rabs_pkg::CFG_RANGE_LOW:  range_low_reg  <= cfg_data;
                rabs_pkg::CFG_RANGE_HIGH: range_high_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // table memory with registered read
    assign wr_en = cmd.mem_wr && (int'(entry_index) < TABLE_DEPTH);

    always_comb
    begin
        unique case (cmd.rd_sel)
            rabs_pkg::RD_LO:  rd_idx = lo_reg[IW-1:0];
            rabs_pkg::RD_MID: rd_idx = mid_w[IW-1:0];
            rabs_pkg::RD_HI:  rd_idx = hi_reg[IW-1:0];
            default:          rd_idx = lo_reg[IW-1:0];
        endcase
    end

    assign rd_addr = AW'(rd_idx);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[AW'(entry_index)] <= item_value;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // search bounds
    always_comb
    begin
        if (int'(range_high_reg) > HI_MAX)
        begin
            hi_init = LW'(HI_MAX);
        end
        else
        begin
            hi_init = signed'({2'b00, range_high_reg});
        end
    end

    assign sum_w = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid_w = sum_w[LW:1];

    assign left_sorted  = vl_reg <= vm_reg;
    assign right_sorted = vm_reg <= rd_data_reg;
    assign in_left      = (target_reg >= vl_reg) && (target_reg <= vm_reg);
    assign in_right     = (target_reg >= vm_reg) && (target_reg <= rd_data_reg);

    assign sts.empty    = lo_reg > hi_reg;
    assign sts.hit      = vm_reg == target_reg;
    assign sts.dead     = !left_sorted && !right_sorted;
    assign sts.out_free = !out_valid_reg || res_ready;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            lo_reg     <= signed'({2'b00, range_low_reg});
            hi_reg     <= hi_init;
            target_reg <= item_value;
        end
        else if (cmd.step && !sts.hit && !sts.dead)
        begin
            // keep the sorted half when it brackets the target, else the other one
            if (left_sorted)
            begin
                if (in_left)
                begin
                    hi_reg <= signed'(mid_w) - LW'(1);
                end
                else
                begin
                    lo_reg <= signed'(mid_w) + LW'(1);
                end
            end
            else
            begin
                if (in_right)
                begin
                    lo_reg <= signed'(mid_w) + LW'(1);
                end
                else
                begin
                    hi_reg <= signed'(mid_w) - LW'(1);
                end
            end
        end
        if (cmd.cap_vl)
        begin
            vl_reg <= rd_data_reg;
        end
        if (cmd.cap_vm)
        begin
            vm_reg <= rd_data_reg;
        end
        if (cmd.res_clear || (cmd.step && !sts.hit && sts.dead))
        begin
            found_reg <= 1'b0;
            match_reg <= '0;
        end
        else if (cmd.step && sts.hit)
        begin
            found_reg <= 1'b1;
            match_reg <= mid_w[IW-1:0];
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            res_found_reg <= found_reg;
            res_idx_reg   <= match_reg;
        end
    end

    assign res_valid       = out_valid_reg;
    assign res_found       = res_found_reg;
    assign res_match_index = res_idx_reg;

endmodule

[rtl/core/rotated_array_binary_search.sv]
// top level of the rotated table search block
//
// requests arrive on req_ch: req_type selects a table write (entry_index,
// item_value) or a search for the target in item_value. a write gives no
// result; a search gives one result on res_ch with found and match_index
// (zero when not found).
// range_low and range_high are set through cfg_we, cfg_index and cfg_data;
// the user must do so only while the block is idle, as the block itself
// does not enforce it. range_high is clamped to the last table entry.
// each search probe reads the low, middle and high entries through the
// single table read port in S_RD_LO, S_RD_MID and S_RD_HI, then compares
// in S_EVAL; a range that runs empty goes straight to S_DONE.
// req_ch.ready is high only while no search is running, so one request is
// worked on at a time; a finished result waits in the output register.
// if res_ch is stalled, a following write is still taken and a following
// search runs, then holds its result until the register is free.
// reset clears the range registers and the control state; table contents
// are undefined until written and need no clearing.
module rotated_array_binary_search
#(
    parameter int TABLE_DEPTH = rabs_pkg::TABLE_DEPTH_DEF
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    rabs_req_if.sink                               req_ch,
    rabs_res_if.source                             res_ch,
    input  logic                                   cfg_we,
    input  logic        [rabs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic        [rabs_pkg::CFG_DATA_W-1:0] cfg_data
);

    rabs_pkg::cmd_t cmd;
    rabs_pkg::sts_t sts;
    logic           req_ready;

    assign req_ch.ready = req_ready;

    rabs_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_ch.valid),
        .req_type  (req_ch.req_type),
        .req_ready (req_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    rabs_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .entry_index     (req_ch.entry_index),
        .item_value      (req_ch.item_value),
        .res_ready       (res_ch.ready),
        .res_valid       (res_ch.valid),
        .res_found       (res_ch.found),
        .res_match_index (res_ch.match_index),
        .cmd             (cmd),
        .sts             (sts)
    );

endmodule

[rtl/core/rabs_chk.sv]
// port level checks for the rotated table search block
module rabs_chk
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        req_valid,
    input logic                        req_ready,
    input logic                        req_type,
    input logic                        res_valid,
    input logic                        res_ready,
    input logic                        res_found,
    input logic [rabs_pkg::IDX_W-1:0]  res_match_index
);

    // a stalled result stays offered
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(res_found) && $stable(res_match_index))
        else $error("result payload changed while stalled");

    // a miss reports index zero
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_found |-> res_match_index == '0)
        else $error("miss with non-zero index");

    // a taken search request closes the input
    a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && req_type == rabs_pkg::REQ_SEARCH |=> !req_ready)
        else $error("request taken during a search");

endmodule

bind rotated_array_binary_search rabs_chk u_rabs_chk
(
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req_ch.valid),
    .req_ready       (req_ch.ready),
    .req_type        (req_ch.req_type),
    .res_valid       (res_ch.valid),
    .res_ready       (res_ch.ready),
    .res_found       (res_ch.found),
    .res_match_index (res_ch.match_index)
);
